@@ hdl/cpr_pkg.sv @@
// Shared types and constants for the clock page replacement block.
`timescale 1ns / 1ps
`default_nettype none

package cpr_pkg;

  localparam int PAGE_W   = 20;
  localparam int POS_W    = 4;
  localparam int TOTAL_W  = 32;
  localparam int CFG_W    = 5;

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  typedef logic [1:0] outcome_t;

  localparam outcome_t OC_HIT  = 2'd0;
  localparam outcome_t OC_FILL = 2'd1;
  localparam outcome_t OC_REPL = 2'd2;
  localparam outcome_t OC_ERR  = 2'd3;

endpackage

`default_nettype wire

@@ hdl/cpr_ram.sv @@
// Resident page store: one write port, one read port with registered data.
`timescale 1ns / 1ps
`default_nettype none

module cpr_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 20
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

@@ hdl/clock_page_replacement.sv @@
// Top level: clock (second-chance) page replacement controller.
// An error result comes straight from idle; otherwise held entries are compared in
// order for a hit, and a miss fills a free entry or scans reference bits for a victim.
// One request at a time; the page store is read one entry per cycle through its
// single read port, and the clock scan tests one reference bit per cycle.
// Synchronous active-low reset clears occupancy, hand, reference bits and count.
// Results are strobed for one cycle; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module clock_page_replacement #(
  parameter int FRAMES    = 16,
  parameter int PAGE_BITS = 20
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [cpr_pkg::PAGE_W-1:0]    in_page_number,
  output logic                               out_valid,
  output cpr_pkg::outcome_t                  out_outcome,
  output logic      [cpr_pkg::POS_W-1:0]     out_position,
  output logic      [cpr_pkg::PAGE_W-1:0]    out_evicted_page,
  output logic      [cpr_pkg::TOTAL_W-1:0]   out_replacement_total,
  input  wire logic                          cfg_wr_en,
  input  wire logic [cpr_pkg::CFG_W-1:0]     cfg_wr_data
);

  import cpr_pkg::*;

  localparam int IDX_W   = $clog2(FRAMES);
  localparam int OCC_W   = $clog2(FRAMES + 1);
  localparam int LIM_W   = (OCC_W > CFG_W) ? OCC_W : CFG_W;
  localparam int STORE_W = (PAGE_BITS < PAGE_W) ? PAGE_BITS : PAGE_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_MISS,
    ST_SCAN,
    ST_REPL
  } state_t;

  state_t               state_r, state_nxt;
  logic [CFG_W-1:0]     cfg_r;
  logic [OCC_W-1:0]     occ_r, occ_nxt;
  logic [IDX_W-1:0]     hand_r, hand_nxt;
  logic [IDX_W-1:0]     cmp_r, cmp_nxt;
  logic [IDX_W-1:0]     scan_r, scan_nxt;
  logic [IDX_W-1:0]     vphys_r, vphys_nxt;
  logic [IDX_W-1:0]     vpos_r, vpos_nxt;
  logic [STORE_W-1:0]   page_r, page_nxt;
  logic [TOTAL_W-1:0]   count_r, count_nxt;
  logic [FRAMES-1:0]    ref_r, ref_nxt;

  logic                 out_valid_r, out_valid_nxt;
  outcome_t             outcome_r, outcome_nxt;
  logic [POS_W-1:0]     position_r, position_nxt;
  logic [PAGE_W-1:0]    evicted_r, evicted_nxt;
  logic [TOTAL_W-1:0]   total_r, total_nxt;

  logic                 mem_we;
  logic [IDX_W-1:0]     mem_wa;
  logic [IDX_W-1:0]     mem_ra;
  logic [STORE_W-1:0]   mem_rd;

  logic [LIM_W-1:0]     cfg_ext, limit, occ_ext;
  logic                 bad_limit, has_room;
  logic [IDX_W-1:0]     occ_m1, scan_phys;

  cpr_ram #(
    .DEPTH (FRAMES),
    .WIDTH (STORE_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_wa),
    .wr_data (page_r),
    .rd_addr (mem_ra),
    .rd_data (mem_rd)
  );

  // Fills append at the next free store entry; list position = occ - 1 - store index.
  assign cfg_ext   = LIM_W'(cfg_r);
  assign limit     = (cfg_ext > LIM_W'(FRAMES)) ? LIM_W'(FRAMES) : cfg_ext;
  assign occ_ext   = LIM_W'(occ_r);
  assign bad_limit = (occ_ext > limit) || (limit == '0);
  assign has_room  = occ_ext < limit;
  assign occ_m1    = IDX_W'(occ_r - OCC_W'(1));
  assign scan_phys = occ_m1 - scan_r;

  always_comb begin
    state_nxt     = state_r;
    occ_nxt       = occ_r;
    hand_nxt      = hand_r;
    cmp_nxt       = cmp_r;
    scan_nxt      = scan_r;
    vphys_nxt     = vphys_r;
    vpos_nxt      = vpos_r;
    page_nxt      = page_r;
    count_nxt     = count_r;
    ref_nxt       = ref_r;
    out_valid_nxt = 1'b0;
    outcome_nxt   = outcome_r;
    position_nxt  = position_r;
    evicted_nxt   = evicted_r;
    total_nxt     = total_r;
    mem_we        = 1'b0;
    mem_wa        = vphys_r;
    mem_ra        = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          page_nxt = STORE_W'(in_page_number);
          if (bad_limit) begin
            out_valid_nxt = 1'b1;
            outcome_nxt   = OC_ERR;
            position_nxt  = '0;
            evicted_nxt   = '0;
            total_nxt     = count_r;
          end else if (occ_r == '0) begin
            state_nxt = ST_MISS;
          end else begin
            cmp_nxt   = '0;
            state_nxt = ST_LOOK;
          end
        end
      end

      ST_LOOK: begin
        // read of the next entry is issued while this one is compared
        mem_ra = cmp_r + IDX_W'(1);
        if (mem_rd == page_r) begin
          ref_nxt[cmp_r] = 1'b1;
          if (has_room) begin
            hand_nxt = '0;
          end
          out_valid_nxt = 1'b1;
          outcome_nxt   = OC_HIT;
          position_nxt  = POS_W'(occ_m1 - cmp_r);
          evicted_nxt   = '0;
          total_nxt     = count_r;
          state_nxt     = ST_IDLE;
        end else if (cmp_r == occ_m1) begin
          state_nxt = ST_MISS;
        end else begin
          cmp_nxt = cmp_r + IDX_W'(1);
        end
      end

      ST_MISS: begin
        if (has_room) begin
          mem_we        = 1'b1;
          mem_wa        = IDX_W'(occ_r);
          ref_nxt[IDX_W'(occ_r)] = 1'b0;
          occ_nxt       = occ_r + OCC_W'(1);
          hand_nxt      = '0;
          out_valid_nxt = 1'b1;
          outcome_nxt   = OC_FILL;
          position_nxt  = '0;
          evicted_nxt   = '0;
          total_nxt     = count_r;
          state_nxt     = ST_IDLE;
        end else begin
          scan_nxt  = (OCC_W'(hand_r) < occ_r) ? hand_r : '0;
          state_nxt = ST_SCAN;
        end
      end

      ST_SCAN: begin
        mem_ra = scan_phys;
        if (!ref_r[scan_phys]) begin
          vphys_nxt = scan_phys;
          vpos_nxt  = scan_r;
          state_nxt = ST_REPL;
        end else begin
          ref_nxt[scan_phys] = 1'b0;
          scan_nxt = (scan_r == occ_m1) ? '0 : scan_r + IDX_W'(1);
        end
      end

      ST_REPL: begin
        // victim page arrives from the read issued in the scan
        mem_we        = 1'b1;
        mem_wa        = vphys_r;
        count_nxt     = count_r + TOTAL_W'(1);
        hand_nxt      = (vpos_r == occ_m1) ? '0 : vpos_r + IDX_W'(1);
        out_valid_nxt = 1'b1;
        outcome_nxt   = OC_REPL;
        position_nxt  = POS_W'(vpos_r);
        evicted_nxt   = PAGE_W'(mem_rd);
        total_nxt     = count_r + TOTAL_W'(1);
        state_nxt     = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cfg_r       <= CFG_RESET;
      occ_r       <= '0;
      hand_r      <= '0;
      count_r     <= '0;
      ref_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      hand_r      <= hand_nxt;
      count_r     <= count_nxt;
      ref_r       <= ref_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        cfg_r <= cfg_wr_data;
      end
    end
    cmp_r      <= cmp_nxt;
    scan_r     <= scan_nxt;
    vphys_r    <= vphys_nxt;
    vpos_r     <= vpos_nxt;
    page_r     <= page_nxt;
    outcome_r  <= outcome_nxt;
    position_r <= position_nxt;
    evicted_r  <= evicted_nxt;
    total_r    <= total_nxt;
  end

  assign busy                  = (state_r != ST_IDLE);
  assign out_valid             = out_valid_r;
  assign out_outcome           = outcome_r;
  assign out_position          = position_r;
  assign out_evicted_page      = evicted_r;
  assign out_replacement_total = total_r;

endmodule

`default_nettype wire

@@ hdl/cpr_checker.sv @@
// Port-level checks for the clock page replacement block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module cpr_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        start,
  input wire logic                        busy,
  input wire logic                        out_valid,
  input wire cpr_pkg::outcome_t           out_outcome,
  input wire logic [cpr_pkg::POS_W-1:0]   out_position,
  input wire logic [cpr_pkg::PAGE_W-1:0]  out_evicted_page
);

  import cpr_pkg::*;

  // an accepted request is either answered at once or keeps the block busy
  a_req_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("request neither answered nor in progress");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobed while still busy");

  a_evict_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_outcome != OC_REPL)) |-> (out_evicted_page == '0))
    else $error("evicted page set without a replacement");

  a_err_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ((out_outcome == OC_ERR) || (out_outcome == OC_FILL)))
      |-> (out_position == '0))
    else $error("error or fill result with non-zero position");

endmodule

bind clock_page_replacement cpr_checker u_cpr_checker (.*);

`default_nettype wire

@@ dv/tb_top.sv @@
// Self-checking testbench for the clock page replacement block.
`timescale 1ns / 1ps

module tb_top;
  import cpr_pkg::*;

  localparam int FRAMES      = 16;
  localparam int PAGE_BITS   = 20;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    outcome_t             oc;
    logic [POS_W-1:0]     pos;
    logic [PAGE_W-1:0]    evicted;
    logic [TOTAL_W-1:0]   total;
  } page_result_t;

  typedef enum logic {ROW_REF, ROW_CFG} row_kind_t;

  // value is the page for a request row, the limit for a config row
  typedef struct packed {
    row_kind_t     kind;
    logic [19:0]   value;
    logic          pinned;
    page_result_t  want;
  } stim_row_t;

  localparam page_result_t NO_PIN = '0;

  localparam int N_DIR = 22;
  localparam stim_row_t DIR_TAB [N_DIR] = '{
    '{ROW_REF, 20'h00000, 1'b1, '{OC_FILL, 4'd0, 20'h0, 32'd0}},
    '{ROW_REF, 20'hFFFFF, 1'b1, '{OC_FILL, 4'd0, 20'h0, 32'd0}},
    '{ROW_REF, 20'h00000, 1'b1, '{OC_HIT,  4'd1, 20'h0, 32'd0}},
    '{ROW_REF, 20'hFFFFF, 1'b0, NO_PIN},
    '{ROW_CFG, 20'd2,     1'b0, NO_PIN},
    // both bits set: first pass clears them, the wrapped pass picks position 0
    '{ROW_REF, 20'h12345, 1'b0, NO_PIN},
    '{ROW_REF, 20'hAAAAA, 1'b0, NO_PIN},
    '{ROW_CFG, 20'd1,     1'b0, NO_PIN},
    '{ROW_REF, 20'h00000, 1'b1, '{OC_ERR,  4'd0, 20'h0, 32'd2}},
    '{ROW_CFG, 20'd0,     1'b0, NO_PIN},
    '{ROW_REF, 20'h55555, 1'b1, '{OC_ERR,  4'd0, 20'h0, 32'd2}},
    // limit above the frame count saturates
    '{ROW_CFG, 20'd31,    1'b0, NO_PIN},
    '{ROW_REF, 20'h12345, 1'b0, NO_PIN},
    '{ROW_REF, 20'h0F0F0, 1'b1, '{OC_FILL, 4'd0, 20'h0, 32'd2}},
    '{ROW_REF, 20'h00001, 1'b0, NO_PIN},
    '{ROW_REF, 20'h80000, 1'b0, NO_PIN},
    '{ROW_CFG, 20'd5,     1'b0, NO_PIN},
    '{ROW_REF, 20'hAAAAA, 1'b0, NO_PIN},
    '{ROW_REF, 20'h7FFFF, 1'b0, NO_PIN},
    '{ROW_REF, 20'h00002, 1'b0, NO_PIN},
    '{ROW_REF, 20'h12345, 1'b0, NO_PIN},
    '{ROW_REF, 20'hFFFFF, 1'b0, NO_PIN}
  };

  localparam int N_PHASES = 16;
  localparam logic [CFG_W-1:0] PHASE_LIMIT [N_PHASES] = '{
    5'd5, 5'd3, 5'd6, 5'd0, 5'd8, 5'd1, 5'd11, 5'd13,
    5'd7, 5'd16, 5'd31, 5'd0, 5'd16, 5'd24, 5'd2, 5'd31
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic [PAGE_W-1:0] in_page_number = '0;
  logic cfg_wr_en = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data = '0;

  logic busy;
  logic out_valid;
  outcome_t out_outcome;
  logic [POS_W-1:0] out_position;
  logic [PAGE_W-1:0] out_evicted_page;
  logic [TOTAL_W-1:0] out_replacement_total;

  // predictor state
  logic [PAGE_W-1:0]  frame_page [FRAMES];
  logic               frame_ref [FRAMES];
  int                 frames_held = 0;
  int                 clock_hand = 0;
  logic [TOTAL_W-1:0] repl_count = '0;
  logic [CFG_W-1:0]   limit_reg = CFG_RESET;

  page_result_t due_results [$];
  page_result_t head_res;
  int n_errors = 0;
  int cycle_count = 0;
  bit fast_mode = 1'b0;

  clock_page_replacement #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_page_number        (in_page_number),
    .out_valid             (out_valid),
    .out_outcome           (out_outcome),
    .out_position          (out_position),
    .out_evicted_page      (out_evicted_page),
    .out_replacement_total (out_replacement_total),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_wr_data           (cfg_wr_data)
  );

  always #2 clk = ~clk;

  task automatic report_error(input string msg);
    if (n_errors < MAX_REPORTS)
      $display("ERROR @%0t: %s", $time, msg);
    n_errors++;
  endtask

  // Second-chance policy: works out the result of one reference and updates state.
  function automatic page_result_t predict_reference(input logic [PAGE_W-1:0] page);
    page_result_t r;
    logic [PAGE_W-1:0] victim;
    int lim;
    int i;
    int scan;
    lim = (limit_reg > FRAMES) ? FRAMES : int'(limit_reg);
    r = '{OC_ERR, '0, '0, repl_count};
    if (frames_held > lim || lim == 0)
      return r;
    for (i = 0; i < frames_held; i++) begin
      if (frame_page[i] == page) begin
        frame_ref[i] = 1'b1;
        if (frames_held < lim)
          clock_hand = 0;
        r.oc  = OC_HIT;
        r.pos = POS_W'(i);
        return r;
      end
    end
    if (frames_held < lim) begin
      for (i = frames_held; i > 0; i--) begin
        frame_page[i] = frame_page[i-1];
        frame_ref[i]  = frame_ref[i-1];
      end
      frame_page[0] = page;
      frame_ref[0]  = 1'b0;
      frames_held++;
      clock_hand = 0;
      r.oc = OC_FILL;
      return r;
    end
    scan = (clock_hand < frames_held) ? clock_hand : 0;
    for (i = 0; i < 2 * frames_held; i++) begin
      if (!frame_ref[scan]) begin
        victim           = frame_page[scan];
        frame_page[scan] = page;
        frame_ref[scan]  = 1'b0;
        repl_count       = repl_count + 1'b1;
        clock_hand       = (scan + 1 < frames_held) ? scan + 1 : 0;
        r = '{OC_REPL, POS_W'(scan), victim, repl_count};
        return r;
      end
      frame_ref[scan] = 1'b0;
      scan = (scan + 1 < frames_held) ? scan + 1 : 0;
    end
    return r;
  endfunction

  // Called at a clock edge; returns at the edge where the request is taken.
  task automatic send_ref(input logic [PAGE_W-1:0] pg, input logic pinned,
                          input page_result_t pin_res);
    int gap;
    page_result_t model_res;
    gap = fast_mode ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    in_page_number <= pg;
    do @(posedge clk); while (busy !== 1'b0);
    model_res = predict_reference(pg);
    due_results.push_back(pinned ? pin_res : model_res);
  endtask

  task automatic wait_idle(input int settle);
    int guard;
    guard = 0;
    start <= 1'b0;
    while (due_results.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_limit(input logic [CFG_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    limit_reg = v;
    cfg_wr_en <= 1'b0;
  endtask

  always @(posedge clk) begin : check_results
    if (rst_n && out_valid === 1'b1) begin
      if (due_results.size() == 0) begin
        report_error($sformatf("result with nothing outstanding (outcome %0d)",
                               out_outcome));
      end else begin
        head_res = due_results.pop_front();
        if (out_outcome !== head_res.oc)
          report_error($sformatf("outcome %0d, want %0d", out_outcome, head_res.oc));
        if (out_position !== head_res.pos)
          report_error($sformatf("position %0d, want %0d", out_position, head_res.pos));
        if (out_evicted_page !== head_res.evicted)
          report_error($sformatf("evicted page %h, want %h",
                                 out_evicted_page, head_res.evicted));
        if (out_replacement_total !== head_res.total)
          report_error($sformatf("replacement total %0d, want %0d",
                                 out_replacement_total, head_res.total));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : stimulus
    int p;
    int k;
    int n_items;
    int ws_size;
    int lim_sat;
    logic [PAGE_W-1:0] working_set [$];
    logic [PAGE_W-1:0] pg;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIR_TAB[r]) begin
      if (DIR_TAB[r].kind == ROW_CFG) begin
        wait_idle(4);
        write_limit(CFG_W'(DIR_TAB[r].value));
      end else begin
        send_ref(DIR_TAB[r].value, DIR_TAB[r].pinned, DIR_TAB[r].want);
      end
    end

    // Limits mostly rise, since the table never shrinks; the low ones give error phases.
    for (p = 0; p < N_PHASES; p++) begin
      wait_idle(4);
      write_limit(PHASE_LIMIT[p]);
      lim_sat = (PHASE_LIMIT[p] > FRAMES) ? FRAMES : int'(PHASE_LIMIT[p]);
      n_items = (lim_sat == 0 || frames_held > lim_sat) ? 30 : 140;
      working_set.delete();
      ws_size = lim_sat + $urandom_range(1, 5);
      repeat (ws_size) working_set.push_back(PAGE_W'($urandom));
      for (k = 0; k < n_items; k++) begin
        if (k % 40 == 0)
          fast_mode = ($urandom_range(0, 3) == 0);
        // a hot half of the working set keeps reference bits set
        case ($urandom_range(0, 7))
          0:       pg = PAGE_W'($urandom);
          1, 2, 3: pg = working_set[$urandom_range(0, ws_size / 2)];
          default: pg = working_set[$urandom_range(0, ws_size - 1)];
        endcase
        send_ref(pg, 1'b0, NO_PIN);
      end
    end

    wait_idle(60);
    if (due_results.size() != 0)
      report_error($sformatf("%0d results never arrived", due_results.size()));
    if (n_errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

@@ clock_page_replacement.f @@
hdl/cpr_pkg.sv
hdl/cpr_ram.sv
hdl/clock_page_replacement.sv
hdl/cpr_checker.sv
dv/tb_top.sv
